>>> sv/m3mi_pkg.sv
// ----------------------------------------------------------------------------
// m3mi_pkg: shared types and constants of the 3x3 matrix unit
// Operation codes, default widths and the controller/datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package m3mi_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DIM   = 3;
  localparam int NELEM = DIM * DIM;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MULL  = 2'd1,
    OP_MULR  = 2'd2,
    OP_INV   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_LOAD  = 4'd1,
    CMD_MAC   = 4'd2,
    CMD_COF   = 4'd3,
    CMD_DET   = 4'd4,
    CMD_DIVGO = 4'd5,
    CMD_COMMIT = 4'd6
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] idx;   // element being produced
    logic [1:0] k;     // term index within the element
    logic       left;  // multiply left when set
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic det_zero;
  } stat_t;
endpackage
`default_nettype wire

>>> sv/matrix3x3_multiply_invert_unit_top.sv
// ----------------------------------------------------------------------------
// matrix3x3_multiply_invert_unit_top: 3x3 fixed-point matrix unit
// Holds one matrix; loads, multiplies left or right, or inverts it per item.
// ----------------------------------------------------------------------------
// The slave channel carries one item per operation: op in tuser and the nine
// operand elements in tdata. The master channel returns the stored matrix
// after the operation in tdata and the singular flag in tuser.
// Steps per item, from accept to the output register: a load writes the
// matrix at accept and hands off; a multiply forms nine elements of three
// products each on the one shared multiplier, then commits and hands off;
// an invert forms the cofactors and the determinant, then nine divisions
// (start, one quotient bit per cycle on the serial divider, then the
// handoff back), then commits and hands off, or skips the divisions and
// the commit and flags the result singular when the determinant is zero.
// One item is in work at a time; the operand is held for the whole item.
// The result sits in an output register; the next item is accepted once
// that register is free or is being taken. A stalled receiver holds the
// result and the block waits. Reset clears the matrix to zero and empties
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module matrix3x3_multiply_invert_unit_top #(
  parameter int DATA_WIDTH = m3mi_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3mi_pkg::FRAC_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire [9*DATA_WIDTH-1:0]   s_axis_tdata,  // e00,e01,e02,e10,..,e22
  input  wire [7:0]                s_axis_tuser,  // op, zero filled
  output logic                     m_axis_tvalid,
  input  wire                      m_axis_tready,
  output logic [9*DATA_WIDTH-1:0]  m_axis_tdata,  // r00,r01,r02,r10,..,r22
  output logic                     m_axis_tuser   // singular
);
  import m3mi_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  res_load, res_singular, in_fire, out_free;
  logic [9*DATA_WIDTH-1:0] result;
  logic [9*DATA_WIDTH-1:0] operand_hold;
  logic [9*DATA_WIDTH-1:0] operand;

  // Output register is free when empty or being drained this cycle.
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // The operand is captured with the item, since the sender may move on
  // while a multiply is still reading it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      operand_hold <= s_axis_tdata;
    end
  end
  assign operand = in_fire ? s_axis_tdata : operand_hold;

  m3mi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_op(s_axis_tuser[1:0]),
    .out_free(out_free), .in_ready(s_axis_tready), .res_load(res_load),
    .res_singular(res_singular), .stat(stat), .cmd(cmd)
  );

  m3mi_datapath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .operand(operand),
    .stat(stat), .result(result)
  );

  // The controller only loads a result when this register is free, so a
  // result load never overwrites an untaken one.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= result;
      m_axis_tuser  <= res_singular;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> sv/m3mi_datapath.sv
// ----------------------------------------------------------------------------
// m3mi_datapath: matrix store, shared multiplier, accumulator and divider
// One product per cycle; the quotient is built one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module m3mi_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  m3mi_pkg::cmd_t               cmd,
  input  wire [9*DATA_WIDTH-1:0]       operand,
  output m3mi_pkg::stat_t              stat,
  output logic [9*DATA_WIDTH-1:0]      result
);
  import m3mi_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int PW  = 2 * W;
  localparam int AW  = PW + 2;
  localparam int NW  = W + FRAC_BITS;
  localparam int QW  = NW;
  localparam int CW  = $clog2(QW + 1);

  logic signed [W-1:0] s   [NELEM];
  logic signed [W-1:0] tmp [NELEM];
  logic signed [W-1:0] adj [NELEM];
  logic signed [W-1:0] e   [NELEM];
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] det;

  always_comb begin
    for (int i = 0; i < NELEM; i++) begin
      e[i] = operand[i*W +: W];
      result[i*W +: W] = s[i];
    end
  end

  // Operand selection for the shared multiplier.
  logic signed [W-1:0] ma, mb;
  logic [1:0] row, col;
  logic       neg;
  always_comb begin
    row = (cmd.idx >= 4'd6) ? 2'd2 : ((cmd.idx >= 4'd3) ? 2'd1 : 2'd0);
    col = 2'(cmd.idx - 4'(row) * 4'd3);
    ma = '0; mb = '0; neg = 1'b0;
    unique case (cmd.kind)
      CMD_MAC: begin
        if (cmd.left) begin
          ma = e[4'(row) * 4'd3 + 4'(cmd.k)];
          mb = s[4'(cmd.k) * 4'd3 + 4'(col)];
        end else begin
          ma = s[4'(row) * 4'd3 + 4'(cmd.k)];
          mb = e[4'(cmd.k) * 4'd3 + 4'(col)];
        end
      end
      CMD_COF: begin
        neg = cmd.k[0];
        unique case ({cmd.idx, cmd.k[0]})
          {4'd0,1'b0}: begin ma = s[4]; mb = s[8]; end
          {4'd0,1'b1}: begin ma = s[7]; mb = s[5]; end
          {4'd1,1'b0}: begin ma = s[2]; mb = s[7]; end
          {4'd1,1'b1}: begin ma = s[1]; mb = s[8]; end
          {4'd2,1'b0}: begin ma = s[1]; mb = s[5]; end
          {4'd2,1'b1}: begin ma = s[2]; mb = s[4]; end
          {4'd3,1'b0}: begin ma = s[5]; mb = s[6]; end
          {4'd3,1'b1}: begin ma = s[3]; mb = s[8]; end
          {4'd4,1'b0}: begin ma = s[0]; mb = s[8]; end
          {4'd4,1'b1}: begin ma = s[2]; mb = s[6]; end
          {4'd5,1'b0}: begin ma = s[3]; mb = s[2]; end
          {4'd5,1'b1}: begin ma = s[0]; mb = s[5]; end
          {4'd6,1'b0}: begin ma = s[3]; mb = s[7]; end
          {4'd6,1'b1}: begin ma = s[6]; mb = s[4]; end
          {4'd7,1'b0}: begin ma = s[6]; mb = s[1]; end
          {4'd7,1'b1}: begin ma = s[0]; mb = s[7]; end
          {4'd8,1'b0}: begin ma = s[0]; mb = s[4]; end
          {4'd8,1'b1}: begin ma = s[3]; mb = s[1]; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      CMD_DET: begin
        ma = s[4'(cmd.k)];
        mb = adj[4'(cmd.k) * 4'd3];
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] term;
  assign prod = ma * mb;
  assign term = AW'(prod >>> FRAC_BITS);

  localparam logic signed [AW-1:0] HI = AW'((64'sd1 <<< (W-1)) - 64'sd1);
  localparam logic signed [AW-1:0] LO = -HI - AW'(1);

  function automatic logic signed [W-1:0] sat(input logic signed [AW-1:0] v);
    if (v > HI) return HI[W-1:0];
    if (v < LO) return LO[W-1:0];
    return v[W-1:0];
  endfunction

  logic signed [AW-1:0] acc_new;
  assign acc_new = (cmd.k == 2'd0) ? (neg ? -term : term)
                                   : (neg ? acc - term : acc + term);

  // Serial restoring divider on magnitudes: |adj| * 2^F / |det|.
  logic [3:0]      didx;
  logic            dbusy;
  logic [CW-1:0]   dcnt;
  logic [NW-1:0]   num;
  logic [AW-1:0]   rem, dmag;
  logic [QW-1:0]   quo;
  logic            qneg;
  logic [AW-1:0]   rtry;
  logic            dlast;
  logic signed [AW-1:0] qs;
  logic signed [W-1:0]  aw;
  assign aw   = adj[cmd.idx];
  assign rtry = {rem[AW-2:0], num[NW-1]};
  assign dlast = dbusy && dcnt == CW'(1);
  assign stat.det_zero = (det == '0);
  assign stat.div_done = !dbusy;

  logic [QW-1:0] qnext;
  assign qnext = {quo[QW-2:0], rtry >= dmag};
  always_comb begin
    qs = qneg ? -AW'(qnext) : AW'(qnext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NELEM; i++) s[i] <= '0;
      dbusy <= 1'b0;
    end else begin
      unique case (cmd.kind)
        CMD_LOAD: for (int i = 0; i < NELEM; i++) s[i] <= e[i];
        CMD_MAC: begin
          acc <= acc_new;
          if (cmd.k == 2'd2) tmp[cmd.idx] <= sat(acc_new);
        end
        CMD_COF: begin
          acc <= acc_new;
          if (cmd.k[0]) adj[cmd.idx] <= sat(acc_new);
        end
        CMD_DET: begin
          acc <= acc_new;
          det <= acc_new;
        end
        CMD_DIVGO: begin
          // A zero determinant ends the invert, so the divider stays idle.
          didx  <= cmd.idx;
          dbusy <= (det != '0);
          dcnt  <= CW'(NW);
          num   <= NW'(aw[W-1] ? -(NW'(aw)) : NW'(aw)) << FRAC_BITS;
          rem   <= '0;
          quo   <= '0;
          dmag  <= det[AW-1] ? -det : det;
          qneg  <= aw[W-1] ^ det[AW-1];
        end
        CMD_COMMIT: for (int i = 0; i < NELEM; i++) s[i] <= tmp[i];
        default: ;
      endcase
      if (dbusy) begin
        rem  <= (rtry >= dmag) ? rtry - dmag : rtry;
        num  <= num << 1;
        quo  <= qnext;
        dcnt <= dcnt - CW'(1);
        if (dlast) begin
          dbusy <= 1'b0;
          tmp[didx] <= sat(qs);
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/m3mi_ctrl.sv
// ----------------------------------------------------------------------------
// m3mi_ctrl: sequencer of the 3x3 matrix unit
// Steps the datapath through products, cofactors, determinant and divisions.
// ----------------------------------------------------------------------------
`default_nettype none
module m3mi_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_fire,
  input  wire [1:0]        in_op,
  input  wire              out_free,
  output logic             in_ready,
  output logic             res_load,
  output logic             res_singular,
  input  m3mi_pkg::stat_t  stat,
  output m3mi_pkg::cmd_t   cmd
);
  import m3mi_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MAC  = 8'b0000_0010,
    S_COF  = 8'b0000_0100,
    S_DET  = 8'b0000_1000,
    S_DIVS = 8'b0001_0000,
    S_DIVW = 8'b0010_0000,
    S_COMM = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t     state;
  logic [3:0] idx;
  logic [1:0] k;
  logic       left, sing;

  assign in_ready = (state == S_IDLE) && out_free;

  // The result is handed over only while the output register can take it.
  assign res_load     = (state == S_DONE) && out_free;
  assign res_singular = sing;

  always_comb begin
    cmd = '{kind: CMD_NONE, idx: idx, k: k, left: left};
    unique case (state)
      S_IDLE: if (in_fire && op_t'(in_op) == OP_LOAD) cmd.kind = CMD_LOAD;
      S_MAC:  cmd.kind = CMD_MAC;
      S_COF:  cmd.kind = CMD_COF;
      S_DET:  cmd.kind = CMD_DET;
      S_DIVS: cmd.kind = CMD_DIVGO;
      S_COMM: cmd.kind = CMD_COMMIT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0; k <= '0; left <= 1'b0; sing <= 1'b0;
    end else begin
      idx <= idx; k <= k;
      unique case (state)
        S_IDLE: if (in_fire) begin
          idx <= '0; k <= '0; sing <= 1'b0;
          left <= (op_t'(in_op) == OP_MULL);
          unique case (op_t'(in_op))
            OP_LOAD: state <= S_DONE;
            OP_INV:  state <= S_COF;
            default: state <= S_MAC;
          endcase
        end
        S_MAC: begin
          if (k == 2'd2) begin
            k <= '0;
            if (idx == 4'd8) state <= S_COMM;
            else idx <= idx + 4'd1;
          end else k <= k + 2'd1;
        end
        S_COF: begin
          if (k == 2'd1) begin
            k <= '0;
            if (idx == 4'd8) state <= S_DET;
            else idx <= idx + 4'd1;
          end else k <= k + 2'd1;
        end
        S_DET: begin
          if (k == 2'd2) begin
            k <= '0; idx <= '0; state <= S_DIVS;
          end else k <= k + 2'd1;
        end
        S_DIVS: begin
          if (stat.det_zero) begin
            sing <= 1'b1; state <= S_DONE;
          end else state <= S_DIVW;
        end
        S_DIVW: if (stat.div_done) begin
          if (idx == 4'd8) state <= S_COMM;
          else begin idx <= idx + 4'd1; state <= S_DIVS; end
        end
        S_COMM: state <= S_DONE;
        S_DONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
